// ===== hw/rtl/qkpd_pkg.sv =====
// Shared types and constants for the quadrature knob PWM dimmer.
`timescale 1ns / 1ps

package qkpd_pkg;

  localparam int unsigned RegW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DUTY_MIN   = 2'd0,
    REG_DUTY_MAX   = 2'd1,
    REG_PERIOD_TOP = 2'd2
  } qkpd_reg_e;

  localparam logic [RegW-1:0] DutyMinRst   = 8'd5;
  localparam logic [RegW-1:0] DutyMaxRst   = 8'd25;
  localparam logic [RegW-1:0] PeriodTopRst = 8'd25;
  localparam logic [RegW-1:0] DutyRst      = 8'd10;

  localparam logic signed [1:0] DirNone = 2'sd0;
  localparam logic signed [1:0] DirUp   = 2'sd1;
  localparam logic signed [1:0] DirDown = -2'sd1;

  localparam logic ReqSample = 1'b0;
  localparam logic ReqTick   = 1'b1;

  typedef struct packed {
    logic [RegW-1:0] duty_min;
    logic [RegW-1:0] duty_max;
    logic [RegW-1:0] period_top;
  } qkpd_cfg_t;

  typedef struct packed {
    logic signed [1:0] step_dir;
    logic [RegW-1:0]   duty_now;
    logic              pwm_out;
  } qkpd_result_t;

endpackage

// ===== hw/rtl/qkpd_core.sv =====
// Encoder decode, duty and PWM phase state with combinational next-state logic.
`timescale 1ns / 1ps

module qkpd_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  req_type_i,
  input  logic                  enc_a_i,
  input  logic                  enc_b_i,
  input  qkpd_pkg::qkpd_cfg_t   cfg_i,
  output qkpd_pkg::qkpd_result_t res_o
);
  import qkpd_pkg::*;

  logic            a_prev_q, a_prev_d;
  logic            b_prev_q, b_prev_d;
  logic            primed_q, primed_d;
  logic [RegW-1:0] duty_q, duty_d;
  logic [RegW-1:0] phase_q, phase_d;
  logic            level_q, level_d;
  logic signed [1:0] dir;

  always_comb begin
    a_prev_d = a_prev_q;
    b_prev_d = b_prev_q;
    primed_d = primed_q;
    duty_d   = duty_q;
    phase_d  = phase_q;
    level_d  = level_q;
    dir      = DirNone;
    if (req_type_i == ReqTick) begin
      phase_d = (phase_q < cfg_i.period_top) ? phase_q + 8'd1 : '0;
      level_d = (phase_d < duty_q);
    end else if (!primed_q) begin
      a_prev_d = enc_a_i;
      b_prev_d = enc_b_i;
      primed_d = 1'b1;
    end else if (enc_a_i != a_prev_q) begin
      a_prev_d = enc_a_i;
      b_prev_d = enc_b_i;
      if (enc_a_i != b_prev_q) begin
        dir = DirUp;
        if (duty_q < cfg_i.duty_max) duty_d = duty_q + 8'd1;
      end else begin
        dir = DirDown;
        if (duty_q > cfg_i.duty_min) duty_d = duty_q - 8'd1;
      end
    end
  end

  assign res_o.step_dir = dir;
  assign res_o.duty_now = duty_d;
  assign res_o.pwm_out  = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_prev_q <= 1'b0;
      b_prev_q <= 1'b0;
      primed_q <= 1'b0;
      duty_q   <= DutyRst;
      phase_q  <= '0;
      level_q  <= 1'b0;
    end else if (en_i) begin
      a_prev_q <= a_prev_d;
      b_prev_q <= b_prev_d;
      primed_q <= primed_d;
      duty_q   <= duty_d;
      phase_q  <= phase_d;
      level_q  <= level_d;
    end
  end

endmodule

// ===== hw/rtl/quadrature_knob_pwm_dimmer.sv =====
// Top level: quadrature knob PWM dimmer with stream ports and config writes.
// Datapath: an accepted transaction is held in the input register, and its result
// goes through the result register to the master side. Throughput: one transaction
// per cycle unless the master side stalls; the state update is one pass of logic.
// Reset: all control state, config registers (5/25/25) and duty (10) are set.
`timescale 1ns / 1ps

module quadrature_knob_pwm_dimmer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [qkpd_pkg::InDataW-1:0]  s_axis_tdata,  // [0] enc_a, [1] enc_b
  input  logic                          s_axis_tuser,  // [0] req_type
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [qkpd_pkg::OutDataW-1:0] m_axis_tdata,  // [0] pwm_out, [8:1] duty_now,
                                                       // [10:9] step_dir
  input  logic                          cfg_we_i,
  input  logic [qkpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [qkpd_pkg::RegW-1:0]     cfg_data_i
);
  import qkpd_pkg::*;

  qkpd_cfg_t    cfg_q;
  logic         in_vld_q;
  logic         req_type_q, enc_a_q, enc_b_q;
  logic         out_vld_q;
  qkpd_result_t res, res_q;
  logic         out_free, advance;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_min   <= DutyMinRst;
      cfg_q.duty_max   <= DutyMaxRst;
      cfg_q.period_top <= PeriodTopRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DUTY_MIN:   cfg_q.duty_min   <= cfg_data_i;
        REG_DUTY_MAX:   cfg_q.duty_max   <= cfg_data_i;
        REG_PERIOD_TOP: cfg_q.period_top <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (out_free) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_type_q <= s_axis_tuser;
      enc_a_q    <= s_axis_tdata[0];
      enc_b_q    <= s_axis_tdata[1];
    end
    if (advance) res_q <= res;
  end

  qkpd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .req_type_i (req_type_q),
    .enc_a_i    (enc_a_q),
    .enc_b_i    (enc_b_q),
    .cfg_i      (cfg_q),
    .res_o      (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, res_q.step_dir, res_q.duty_now, res_q.pwm_out};

endmodule
